/* rtl/ppst_pkg.sv */
`default_nettype none

package ppst_pkg;

    // Internal angle width (radians, 20 fraction bits)
    localparam int ZW = 26;
    // Sine unit data width
    localparam int SW = 34;
    // Number of CORDIC micro-rotations
    localparam int CORDIC_STEPS = 20;

    localparam logic signed [ZW-1:0] ANG_PI      = ZW'(3294199);
    localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(1647099);
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = ZW'(6588398);
    localparam logic signed [SW-1:0] GAIN_INV    = SW'(652032874);

    // Normalization window for the vectoring CORDIC
    localparam int NORM_LOW_BIT  = 40;
    localparam int NORM_HIGH_BIT = 41;

    // Fixed scale of the lookahead term in the steering atan2
    localparam int LD_SCALE_SHIFT = 16;
    // Shift that brings 2*L*sin back to the lookahead scale
    localparam int NUM_SHIFT = 14;
    // Rounding of internal angles to the port format
    localparam int ANG_OUT_SHIFT = 8;
    localparam int SQRT_STEPS = 33;

    // Configuration register indexes
    localparam logic [2:0] CFG_WHEELBASE      = 3'd0;
    localparam logic [2:0] CFG_BASE_LOOKAHEAD = 3'd1;
    localparam logic [2:0] CFG_LOOKAHEAD_GAIN = 3'd2;
    localparam logic [2:0] CFG_STEER_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_WAYPOINT_COUNT = 3'd4;

    // Input word kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_POSE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       wr_load;
        logic       cap_pose;
        logic       ld_sum;
        logic       scan_rd;
        logic       walk_rd;
        logic       sqrt_step;
        logic       walk_acc;
        logic       at_load;
        logic       at_src;
        logic       at_norm;
        logic       at_rot;
        logic       alpha;
        logic       wrap;
        logic       sin_init;
        logic       sin_rot;
        logic       num_mul;
        logic       fin;
        logic [4:0] step;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
        logic walk_more;
        logic at_zero;
        logic at_low;
        logic at_high;
        logic in_range;
    } sts_t;

    // atan(2^-i) in radians, 20 fraction bits
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = ZW'(823550);
            5'd1:  r = ZW'(486170);
            5'd2:  r = ZW'(256879);
            5'd3:  r = ZW'(130396);
            5'd4:  r = ZW'(65451);
            5'd5:  r = ZW'(32757);
            5'd6:  r = ZW'(16383);
            5'd7:  r = ZW'(8192);
            5'd8:  r = ZW'(4096);
            5'd9:  r = ZW'(2048);
            5'd10: r = ZW'(1024);
            5'd11: r = ZW'(512);
            5'd12: r = ZW'(256);
            5'd13: r = ZW'(128);
            5'd14: r = ZW'(64);
            5'd15: r = ZW'(32);
            5'd16: r = ZW'(16);
            5'd17: r = ZW'(8);
            5'd18: r = ZW'(4);
            5'd19: r = ZW'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ppst_ram.sv */
`default_nettype none

module ppst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/ppst_ctrl.sv */
`default_nettype none

module ppst_ctrl import ppst_pkg::*; #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               req_type,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    input  wire logic [$clog2(MAX_WAYPOINTS):0]     n,
    input  wire sts_t                               sts,
    output cmd_t                                    cmd,
    output logic [$clog2(MAX_WAYPOINTS)-1:0]        scan_addr
);

    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int N_W   = IDX_W + 1;
    localparam int CNT_W = (N_W > 6) ? N_W : 6;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LDS   = 5'd1;
    localparam logic [4:0] S_SCAN  = 5'd2;
    localparam logic [4:0] S_SCANW = 5'd3;
    localparam logic [4:0] S_WCHK  = 5'd4;
    localparam logic [4:0] S_WRD   = 5'd5;
    localparam logic [4:0] S_WWAIT = 5'd6;
    localparam logic [4:0] S_SQRT  = 5'd7;
    localparam logic [4:0] S_WACC  = 5'd8;
    localparam logic [4:0] S_ATLD  = 5'd9;
    localparam logic [4:0] S_ANORM = 5'd10;
    localparam logic [4:0] S_AROT  = 5'd11;
    localparam logic [4:0] S_ALPHA = 5'd12;
    localparam logic [4:0] S_WRAP  = 5'd13;
    localparam logic [4:0] S_SINI  = 5'd14;
    localparam logic [4:0] S_SROT  = 5'd15;
    localparam logic [4:0] S_MUL   = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    localparam logic PH_HEADING = 1'b0;
    localparam logic PH_STEER   = 1'b1;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign scan_addr = cnt_reg[IDX_W-1:0];

    // Write load words while idle; sequence one pose through scan, walk and the two angle units
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.step   = cnt_reg[4:0];
        cmd.at_src = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.wr_load = 1'b1;
                    end
                    else if (n != '0)
                    begin
                        cmd.cap_pose = 1'b1;
                        state_next   = S_LDS;
                    end
                end
            end
            S_LDS:
            begin
                cmd.ld_sum = 1'b1;
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg < CNT_W'(n))
                begin
                    cmd.scan_rd = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (sts.walk_more)
                begin
                    state_next = S_WRD;
                end
                else
                begin
                    phase_next = PH_HEADING;
                    state_next = S_ATLD;
                end
            end
            S_WRD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WWAIT;
            end
            S_WWAIT:
            begin
                if (!sts.pipe_busy)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_WACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WACC:
            begin
                cmd.walk_acc = 1'b1;
                state_next   = S_WCHK;
            end
            S_ATLD:
            begin
                cmd.at_load = 1'b1;
                state_next  = S_ANORM;
            end
            S_ANORM:
            begin
                if (sts.at_zero)
                begin
                    state_next = (phase_reg == PH_STEER) ? S_FIN : S_ALPHA;
                end
                else if (sts.at_low || sts.at_high)
                begin
                    cmd.at_norm = 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_AROT;
                end
            end
            S_AROT:
            begin
                cmd.at_rot = 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = (phase_reg == PH_STEER) ? S_FIN : S_ALPHA;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ALPHA:
            begin
                cmd.alpha  = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (sts.in_range)
                begin
                    state_next = S_SINI;
                end
                else
                begin
                    cmd.wrap = 1'b1;
                end
            end
            S_SINI:
            begin
                cmd.sin_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_SROT;
            end
            S_SROT:
            begin
                cmd.sin_rot = 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.num_mul = 1'b1;
                phase_next  = PH_STEER;
                state_next  = S_ATLD;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= PH_HEADING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ppst_datapath.sv */
`default_nettype none

module ppst_datapath import ppst_pkg::*; #(
    parameter int MAX_WAYPOINTS   = 1024,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cmd_t                           cmd,
    output sts_t                                sts,
    input  wire logic [$clog2(MAX_WAYPOINTS)-1:0] scan_addr,
    input  wire logic [$clog2(MAX_WAYPOINTS):0] n,
    input  wire logic [9:0]                     slot,
    input  wire logic signed [31:0]             point_x,
    input  wire logic signed [31:0]             point_y,
    input  wire logic signed [14:0]             heading,
    input  wire logic signed [31:0]             speed,
    input  wire logic [22:0]                    wheelbase,
    input  wire logic [22:0]                    base_lookahead,
    input  wire logic [19:0]                    lookahead_gain,
    input  wire logic [12:0]                    steer_limit,
    output logic signed [13:0]                  steer_angle,
    output logic [9:0]                          target_index,
    output logic                                clamped
);

    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int N_W   = IDX_W + 1;
    localparam int SXW   = (N_W > 11) ? N_W : 11;
    localparam int LDW   = ((53 - COORD_FRAC_BITS > 24) ? 53 - COORD_FRAC_BITS : 24) + 1;
    localparam int AW    = (LDW + LD_SCALE_SHIFT + 2 > 46) ? LDW + LD_SCALE_SHIFT + 2 : 46;
    localparam int WKW   = 34 + IDX_W;
    localparam int CMPW  = ((WKW > LDW) ? WKW : LDW) + 1;

    // ---------------- waypoint tables ----------------
    logic [SXW-1:0]   slot_x;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rx, ry;
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign slot_x  = SXW'(slot);
    assign wr_en   = cmd.wr_load && (slot_x < SXW'(MAX_WAYPOINTS));
    assign rd_addr = cmd.walk_rd ? IDX_W'(idx_reg + 1'b1) : scan_addr;

    ppst_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_x[IDX_W-1:0]),
        .wdata (point_x),
        .raddr (rd_addr),
        .rdata (rx)
    );

    ppst_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_x[IDX_W-1:0]),
        .wdata (point_y),
        .raddr (rd_addr),
        .rdata (ry)
    );

    // ---------------- pose capture and lookahead ----------------
    logic signed [31:0]    pos_x_reg, pos_y_reg;
    logic signed [14:0]    yaw_reg;
    logic signed [52:0]    ldp_reg;
    logic [LDW-1:0]        ld_reg;
    logic signed [53:0]    ld_sum;

    assign ld_sum = 54'(ldp_reg >>> COORD_FRAC_BITS) + $signed({31'd0, base_lookahead});

    always_ff @(posedge clk)
    begin
        if (cmd.cap_pose)
        begin
            pos_x_reg <= point_x;
            pos_y_reg <= point_y;
            yaw_reg   <= heading;
            ldp_reg   <= $signed({1'b0, lookahead_gain}) * speed;
        end
        // Saturate the lookahead at zero
        if (cmd.ld_sum)
        begin
            ld_reg <= ld_sum[53] ? '0 : LDW'(ld_sum);
        end
    end

    // ---------------- distance pipeline ----------------
    logic               v1_reg, v2_reg, v3_reg;
    logic               m1_reg, m2_reg, m3_reg;
    logic [IDX_W-1:0]   i1_reg, i2_reg, i3_reg;
    logic signed [32:0] dx2_reg, dy2_reg;
    logic [31:0]        px2_reg, py2_reg, px3_reg, py3_reg;
    logic [63:0]        sqx3_reg, sqy3_reg;
    logic signed [31:0] ref_x, ref_y;
    logic signed [31:0] cur_x_reg, cur_y_reg, nxt_x_reg, nxt_y_reg;
    logic [31:0]        mag_x, mag_y;
    logic [64:0]        d2_sum;
    logic [64:0]        best_reg;
    logic               best_ok_reg;

    assign ref_x  = m1_reg ? cur_x_reg : pos_x_reg;
    assign ref_y  = m1_reg ? cur_y_reg : pos_y_reg;
    assign mag_x  = dx2_reg[32] ? 32'(-dx2_reg) : 32'(dx2_reg);
    assign mag_y  = dy2_reg[32] ? 32'(-dy2_reg) : 32'(dy2_reg);
    assign d2_sum = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_rd || cmd.walk_rd;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Difference, square, then compare or hand to the root unit
    always_ff @(posedge clk)
    begin
        m1_reg   <= cmd.walk_rd;
        i1_reg   <= rd_addr;
        m2_reg   <= m1_reg;
        i2_reg   <= i1_reg;
        dx2_reg  <= $signed({rx[31], rx}) - $signed({ref_x[31], ref_x});
        dy2_reg  <= $signed({ry[31], ry}) - $signed({ref_y[31], ref_y});
        px2_reg  <= rx;
        py2_reg  <= ry;
        m3_reg   <= m2_reg;
        i3_reg   <= i2_reg;
        sqx3_reg <= mag_x * mag_x;
        sqy3_reg <= mag_y * mag_y;
        px3_reg  <= px2_reg;
        py3_reg  <= py2_reg;
    end

    // ---------------- nearest point and walk ----------------
    logic [34:0]      rem_reg;
    logic [32:0]      root_reg;
    logic [65:0]      sq_reg;
    logic [36:0]      r2, trial;
    logic             ge;
    logic [WKW-1:0]   walked_reg;

    assign r2    = {rem_reg, sq_reg[65:64]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_pose)
        begin
            best_ok_reg <= 1'b0;
            walked_reg  <= '0;
        end
        else if (v3_reg && !m3_reg)
        begin
            // Lowest index wins on a tie
            if (!best_ok_reg || (d2_sum < best_reg))
            begin
                best_reg    <= d2_sum;
                best_ok_reg <= 1'b1;
                idx_reg     <= i3_reg;
                cur_x_reg   <= px3_reg;
                cur_y_reg   <= py3_reg;
            end
        end
        else if (cmd.walk_acc)
        begin
            walked_reg <= walked_reg + WKW'(root_reg);
            idx_reg    <= idx_next;
            cur_x_reg  <= nxt_x_reg;
            cur_y_reg  <= nxt_y_reg;
        end

        // Load the segment length square, then one root bit per step
        if (v3_reg && m3_reg)
        begin
            nxt_x_reg <= px3_reg;
            nxt_y_reg <= py3_reg;
            sq_reg    <= {1'b0, d2_sum};
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_reg   <= {sq_reg[63:0], 2'b00};
            rem_reg  <= ge ? 35'(r2 - trial) : 35'(r2);
            root_reg <= {root_reg[31:0], ge};
        end
    end

    assign idx_next = IDX_W'(idx_reg + 1'b1);

    // ---------------- vectoring CORDIC (atan2) ----------------
    logic signed [AW-1:0] ax, ay, nx, ny, my;
    logic signed [AW-1:0] cx_reg, cy_reg;
    logic [AW-1:0]        cm_reg, m_new;
    logic signed [ZW-1:0] cz_reg, off, tab;
    logic                 zero_reg, neg;
    logic signed [58:0]   prod2_reg, num_full;
    logic signed [AW-1:0] cxs, cys;

    assign num_full = prod2_reg >>> NUM_SHIFT;
    assign tab      = atan_entry(cmd.step);

    always_comb
    begin
        if (cmd.at_src)
        begin
            ay = AW'(num_full);
            ax = $signed(AW'(ld_reg)) <<< LD_SCALE_SHIFT;
        end
        else
        begin
            ay = AW'($signed({cur_y_reg[31], cur_y_reg}) - $signed({pos_y_reg[31], pos_y_reg}));
            ax = AW'($signed({cur_x_reg[31], cur_x_reg}) - $signed({pos_x_reg[31], pos_x_reg}));
        end
        neg = ax[AW-1];
        nx  = neg ? -ax : ax;
        ny  = neg ? -ay : ay;
        off = !neg ? '0 : ((ny <= 0) ? ANG_PI : -ANG_PI);
        my  = ny[AW-1] ? -ny : ny;
        m_new = ($unsigned(nx) > $unsigned(my)) ? $unsigned(nx) : $unsigned(my);
    end

    assign cxs = cx_reg >>> cmd.step;
    assign cys = cy_reg >>> cmd.step;

    always_ff @(posedge clk)
    begin
        if (cmd.at_load)
        begin
            cx_reg   <= nx;
            cy_reg   <= ny;
            cm_reg   <= m_new;
            cz_reg   <= off;
            zero_reg <= (ax == '0) && (ay == '0);
        end
        else if (cmd.at_norm)
        begin
            // Bring the larger magnitude into the window
            if (cm_reg < (AW'(1) << NORM_LOW_BIT))
            begin
                cx_reg <= cx_reg <<< 1;
                cy_reg <= cy_reg <<< 1;
                cm_reg <= cm_reg << 1;
            end
            else
            begin
                cx_reg <= cx_reg >>> 1;
                cy_reg <= cy_reg >>> 1;
                cm_reg <= cm_reg >> 1;
            end
        end
        else if (cmd.at_rot)
        begin
            if (!cy_reg[AW-1])
            begin
                cx_reg <= cx_reg + cys;
                cy_reg <= cy_reg - cxs;
                cz_reg <= cz_reg + tab;
            end
            else
            begin
                cx_reg <= cx_reg - cys;
                cy_reg <= cy_reg + cxs;
                cz_reg <= cz_reg - tab;
            end
        end
    end

    // ---------------- rotation CORDIC (sin) ----------------
    logic signed [SW-1:0] sx_reg, sy_reg, sxs, sys;
    logic signed [ZW-1:0] sz_reg, yaw_ang;

    assign sxs     = sx_reg >>> cmd.step;
    assign sys     = sy_reg >>> cmd.step;
    assign yaw_ang = $signed({{(ZW - 15){yaw_reg[14]}}, yaw_reg}) <<< ANG_OUT_SHIFT;

    always_ff @(posedge clk)
    begin
        if (cmd.alpha)
        begin
            sz_reg <= cz_reg - yaw_ang;
        end
        else if (cmd.wrap)
        begin
            sz_reg <= (sz_reg > ANG_PI) ? sz_reg - ANG_TWO_PI : sz_reg + ANG_TWO_PI;
        end
        else if (cmd.sin_init)
        begin
            // Fold into the right half plane
            sx_reg <= GAIN_INV;
            sy_reg <= '0;
            if (sz_reg > ANG_HALF_PI)
            begin
                sz_reg <= ANG_PI - sz_reg;
            end
            else if (sz_reg < -ANG_HALF_PI)
            begin
                sz_reg <= -ANG_PI - sz_reg;
            end
        end
        else if (cmd.sin_rot)
        begin
            if (!sz_reg[ZW-1])
            begin
                sx_reg <= sx_reg - sys;
                sy_reg <= sy_reg + sxs;
                sz_reg <= sz_reg - tab;
            end
            else
            begin
                sx_reg <= sx_reg + sys;
                sy_reg <= sy_reg - sxs;
                sz_reg <= sz_reg + tab;
            end
        end

        if (cmd.num_mul)
        begin
            prod2_reg <= 59'($signed({1'b0, wheelbase, 1'b0}) * sy_reg);
        end
    end

    // ---------------- result ----------------
    logic signed [ZW-1:0] st, lim_s;

    assign st    = (cz_reg + ZW'(128)) >>> ANG_OUT_SHIFT;
    assign lim_s = $signed(ZW'(steer_limit));

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            target_index <= 10'(idx_reg);
            if (st > lim_s)
            begin
                steer_angle <= 14'(lim_s);
                clamped     <= 1'b1;
            end
            else if (st < -lim_s)
            begin
                steer_angle <= 14'(-lim_s);
                clamped     <= 1'b1;
            end
            else
            begin
                steer_angle <= 14'(st);
                clamped     <= 1'b0;
            end
        end
    end

    // ---------------- status ----------------
    assign sts.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign sts.walk_more = (CMPW'(walked_reg) < CMPW'(ld_reg))
                           && (N_W'(idx_reg) + 1'b1 < n);
    assign sts.at_zero   = zero_reg;
    assign sts.at_low    = cm_reg < (AW'(1) << NORM_LOW_BIT);
    assign sts.at_high   = cm_reg >= (AW'(1) << NORM_HIGH_BIT);
    assign sts.in_range  = (sz_reg <= ANG_PI) && (sz_reg >= -ANG_PI);

endmodule

`default_nettype wire

/* rtl/pure_pursuit_steering.sv */
`default_nettype none

// Pure pursuit steering. Load words (req_type 0) write one waypoint into the
// table and produce no result. A pose word (req_type 1) produces one result
// word with the clamped steering angle, the index of the chosen target
// waypoint and a clamp flag; with waypoint_count zero it produces nothing.
// A pose runs the nearest-point scan (one table read per cycle through a
// four-stage distance pipeline), a walk along the path with the
// one-bit-per-cycle square root for each segment, the two CORDIC atan2 runs,
// whose normalization shifts one bit per cycle, and the sine. One word is in
// work at a time; a finished result waits in the output register while the
// next word is accepted. Configuration is written through cfg_we, cfg_index,
// cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. The waypoint table has no reset.
module pure_pursuit_steering import ppst_pkg::*; #(
    parameter int MAX_WAYPOINTS   = 1024,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic [9:0]         slot,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [14:0] heading,
    input  wire logic signed [31:0] speed,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [13:0]      steer_angle,
    output logic [9:0]              target_index,
    output logic                    clamped,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [22:0]        cfg_data
);

    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int N_W   = IDX_W + 1;
    localparam int CMW   = (N_W > 11) ? N_W : 11;

    logic [22:0]      wheelbase_reg, base_lookahead_reg;
    logic [19:0]      lookahead_gain_reg;
    logic [12:0]      steer_limit_reg;
    logic [10:0]      waypoint_count_reg;
    logic [N_W-1:0]   n;
    logic             in_ready_i;
    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] scan_addr;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg      <= 23'd26214;
            base_lookahead_reg <= 23'd32768;
            lookahead_gain_reg <= 20'd6554;
            steer_limit_reg    <= 13'd3217;
            waypoint_count_reg <= 11'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WHEELBASE:      wheelbase_reg      <= cfg_data;
                CFG_BASE_LOOKAHEAD: base_lookahead_reg <= cfg_data;
                CFG_LOOKAHEAD_GAIN: lookahead_gain_reg <= cfg_data[19:0];
                CFG_STEER_LIMIT:    steer_limit_reg    <= cfg_data[12:0];
                CFG_WAYPOINT_COUNT: waypoint_count_reg <= cfg_data[10:0];
                default:            ;
            endcase
        end
    end

    // Limit the waypoint count to the table depth
    assign n = (CMW'(waypoint_count_reg) > CMW'(MAX_WAYPOINTS))
               ? N_W'(MAX_WAYPOINTS) : N_W'(waypoint_count_reg);

    assign in_ready = in_ready_i;

    ppst_ctrl #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready_i),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .n         (n),
        .sts       (sts),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    ppst_datapath #(
        .MAX_WAYPOINTS   (MAX_WAYPOINTS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .scan_addr      (scan_addr),
        .n              (n),
        .slot           (slot),
        .point_x        (point_x),
        .point_y        (point_y),
        .heading        (heading),
        .speed          (speed),
        .wheelbase      (wheelbase_reg),
        .base_lookahead (base_lookahead_reg),
        .lookahead_gain (lookahead_gain_reg),
        .steer_limit    (steer_limit_reg),
        .steer_angle    (steer_angle),
        .target_index   (target_index),
        .clamped        (clamped)
    );

endmodule

`default_nettype wire
